/* rtl/xmt_pkg.sv */
// xmt_pkg: shared types, codes and constants of the XML markup tokenizer.
// Used by xmt_front, xmt_queue, xmt_engine and xml_markup_tokenizer.
// No dependencies.
`default_nettype none

package xmt_pkg;

    localparam int unsigned LINE_W        = 32;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam logic [LINE_W-1:0] START_LINE_RESET = 32'd1;
    localparam logic [LINE_W-1:0] LINE_MAX  = 32'hFFFF_FFFF;

    // Characters the classifier looks for
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    // Byte roles
    localparam logic [2:0] ROLE_MARKUP = 3'd0;
    localparam logic [2:0] ROLE_TEXT   = 3'd1;
    localparam logic [2:0] ROLE_NAME   = 3'd2;
    localparam logic [2:0] ROLE_ATTR   = 3'd3;
    localparam logic [2:0] ROLE_VALUE  = 3'd4;
    localparam logic [2:0] ROLE_CMT    = 3'd5;

    // Close events
    localparam logic [2:0] CLOSE_NONE    = 3'd0;
    localparam logic [2:0] CLOSE_TAG     = 3'd1;
    localparam logic [2:0] CLOSE_CMT     = 3'd2;
    localparam logic [2:0] CLOSE_TEXT_LT = 3'd3;
    localparam logic [2:0] CLOSE_TEXT_END = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SLASH    = 3'd1;
    localparam logic [2:0] ERR_QMARK    = 3'd2;
    localparam logic [2:0] ERR_QUOTE    = 3'd3;
    localparam logic [2:0] ERR_ATTR     = 3'd4;
    localparam logic [2:0] ERR_UNCLOSED = 3'd5;

    typedef enum logic [14:0] {
        MODE_FRESH   = 15'h0001,
        MODE_IDLE    = 15'h0002,
        MODE_TEXT    = 15'h0004,
        MODE_LT      = 15'h0008,
        MODE_NAME    = 15'h0010,
        MODE_CMT     = 15'h0020,
        MODE_TOP     = 15'h0040,
        MODE_TOPSKIP = 15'h0080,
        MODE_SLASH   = 15'h0100,
        MODE_ANAME   = 15'h0200,
        MODE_ANSKIP  = 15'h0400,
        MODE_EQ      = 15'h0800,
        MODE_QVAL    = 15'h1000,
        MODE_UVAL    = 15'h2000,
        MODE_ERR     = 15'h4000
    } mode_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [7:0]        byte_out;
        logic [2:0]        role;
        logic              part_start;
        logic [2:0]        close_event;
        logic              self_closing;
        logic              valueless_attr;
        logic [2:0]        error_code;
        logic [LINE_W-1:0] line_number;
    } out_t;

    // Character class flags computed in the front end
    typedef struct packed {
        logic space;
        logic lt;
        logic gt;
        logic slash;
        logic qmark;
        logic bang;
        logic dash;
        logic eq;
        logic dquote;
        logic squote;
        logic letter;
        logic attr_char;
        logic newline;
    } class_t;

    typedef struct packed {
        in_t    item;
        class_t cls;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/xmt_front.sv */
// xmt_front: input stage of the tokenizer; takes bytes and classifies them.
// Depends on xmt_pkg.
`default_nettype none

module xmt_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire xmt_pkg::in_t  s_data,
    output logic               push_valid,
    input  wire logic          push_ready,
    output xmt_pkg::entry_t    push_data
);
    import xmt_pkg::*;

    logic   vld_reg;
    entry_t ent_reg;
    class_t cls;
    logic [7:0] c;

    assign c = s_data.byte_in;

    always_comb begin
        cls.space     = c inside {CH_SP, CH_CR, CH_TAB, CH_NL};
        cls.lt        = (c == CH_LT);
        cls.gt        = (c == CH_GT);
        cls.slash     = (c == CH_SLASH);
        cls.qmark     = (c == CH_QMARK);
        cls.bang      = (c == CH_BANG);
        cls.dash      = (c == CH_DASH);
        cls.eq        = (c == CH_EQ);
        cls.dquote    = (c == CH_DQUOTE);
        cls.squote    = (c == CH_SQUOTE);
        cls.letter    = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
        cls.attr_char = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                                   CH_UNDER, CH_DOLLAR, CH_COLON, CH_DOT, CH_DASH});
        cls.newline   = (c == CH_NL);
    end

    assign s_ready    = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_data  = ent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            vld_reg <= 1'b1;
        end else if (push_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ent_reg.item <= s_data;
            ent_reg.cls  <= cls;
        end
    end

endmodule

`default_nettype wire

/* rtl/xmt_queue.sv */
// xmt_queue: short FIFO of classified bytes between front end and engine.
// Depends on xmt_pkg.
`default_nettype none

module xmt_queue #(
    parameter int unsigned DEPTH = xmt_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire xmt_pkg::entry_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output xmt_pkg::entry_t      pop_data
);
    import xmt_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/xmt_engine.sv */
// xmt_engine: tokenizer state machine and result register.
// Consumes classified bytes from xmt_queue. Depends on xmt_pkg.
`default_nettype none

module xmt_engine (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [xmt_pkg::LINE_W-1:0] start_line,
    input  wire logic                       pop_valid,
    output logic                            pop_ready,
    input  wire xmt_pkg::entry_t            pop_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output xmt_pkg::out_t                   m_data
);
    import xmt_pkg::*;

    mode_t             mode_reg, mode_next, mode_eff;
    logic [LINE_W-1:0] line_reg, line_next, line_here;
    logic              nq_reg, nq_next;
    logic              qs_reg, qs_next;
    logic [1:0]        bdm_reg, bdm_next;
    logic [1:0]        dh_reg, dh_next;
    logic [1:0]        bls_reg, bls_next;
    logic              ps_reg, ps_next;
    logic [2:0]        err_reg, err_next;
    logic              out_valid_reg;
    out_t              out_reg, res;
    logic              consume;
    logic              was_err;
    logic              do_top;
    logic              after_name;
    class_t            cls;
    logic              last;

    assign cls       = pop_data.cls;
    assign last      = pop_data.item.is_last;
    assign pop_ready = !out_valid_reg || m_ready;
    assign consume   = pop_valid && pop_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        res            = '0;
        res.byte_out   = pop_data.item.byte_in;
        mode_eff       = (mode_reg == MODE_FRESH) ? MODE_IDLE : mode_reg;
        line_here      = (mode_reg == MODE_FRESH) ? start_line : line_reg;
        was_err        = (mode_reg == MODE_ERR);
        mode_next      = mode_eff;
        nq_next        = nq_reg;
        qs_next        = qs_reg;
        bdm_next       = bdm_reg;
        dh_next        = dh_reg;
        bls_next       = bls_reg;
        ps_next        = ps_reg;
        err_next       = err_reg;
        do_top         = 1'b0;
        after_name     = 1'b0;

        case (mode_eff)
            MODE_IDLE, MODE_TEXT: begin
                if (cls.lt) begin
                    if (mode_eff == MODE_TEXT) begin
                        res.close_event = CLOSE_TEXT_LT;
                    end
                    nq_next   = 1'b0;
                    bdm_next  = 2'd0;
                    ps_next   = 1'b0;
                    mode_next = MODE_LT;
                end else begin
                    res.role = ROLE_TEXT;
                    if (mode_eff == MODE_IDLE) begin
                        res.part_start = 1'b1;
                        mode_next      = MODE_TEXT;
                    end
                end
            end
            MODE_LT: begin
                if (cls.gt) begin
                    do_top = 1'b1;
                end else if (!cls.space) begin
                    res.role       = ROLE_NAME;
                    res.part_start = 1'b1;
                    nq_next        = cls.qmark;
                    bdm_next       = cls.bang ? 2'd1 : 2'd0;
                    mode_next      = MODE_NAME;
                end
            end
            MODE_NAME: begin
                if (cls.space || cls.slash || cls.gt) begin
                    do_top = 1'b1;
                end else begin
                    res.role = ROLE_NAME;
                    if (bdm_reg == 2'd1 && cls.dash) begin
                        bdm_next = 2'd2;
                    end else if (bdm_reg == 2'd2 && cls.dash) begin
                        // fourth byte of "<!--": open the comment
                        bdm_next       = 2'd0;
                        res.role       = ROLE_MARKUP;
                        res.part_start = 1'b1;
                        dh_next        = 2'd0;
                        bls_next       = 2'd0;
                        mode_next      = MODE_CMT;
                    end else begin
                        bdm_next = 2'd0;
                    end
                end
            end
            MODE_CMT: begin
                if (cls.gt && bls_reg == 2'd3 && dh_reg == 2'd3) begin
                    res.close_event = CLOSE_CMT;
                    mode_next       = MODE_IDLE;
                end else begin
                    res.role = ROLE_CMT;
                    dh_next  = {dh_reg[0], cls.dash};
                    if (bls_reg != 2'd3) begin
                        bls_next = bls_reg + 2'd1;
                    end
                end
            end
            MODE_TOP, MODE_TOPSKIP: begin
                do_top = 1'b1;
            end
            MODE_SLASH: begin
                if (cls.gt) begin
                    do_top = 1'b1;
                end else if (!cls.space) begin
                    err_next  = ERR_SLASH;
                    mode_next = MODE_ERR;
                end
            end
            MODE_ANAME: begin
                if (cls.attr_char) begin
                    res.role = ROLE_ATTR;
                end else begin
                    after_name = 1'b1;
                end
            end
            MODE_ANSKIP: begin
                after_name = 1'b1;
            end
            MODE_EQ: begin
                if (cls.dquote || cls.squote) begin
                    qs_next   = cls.squote;
                    bls_next  = 2'd0;
                    mode_next = MODE_QVAL;
                end else if (cls.space) begin
                    mode_next = MODE_EQ;
                end else if (cls.slash || cls.gt) begin
                    do_top = 1'b1;
                end else begin
                    res.role       = ROLE_VALUE;
                    res.part_start = 1'b1;
                    mode_next      = MODE_UVAL;
                end
            end
            MODE_QVAL: begin
                if (qs_reg ? cls.squote : cls.dquote) begin
                    mode_next = MODE_TOP;
                end else begin
                    res.role       = ROLE_VALUE;
                    res.part_start = (bls_reg == 2'd0);
                    if (bls_reg != 2'd3) begin
                        bls_next = bls_reg + 2'd1;
                    end
                end
            end
            MODE_UVAL: begin
                if (cls.space || cls.slash || cls.gt) begin
                    do_top = 1'b1;
                end else begin
                    res.role = ROLE_VALUE;
                end
            end
            default: begin
                // error mode: hold everything until the document ends
            end
        endcase

        // end of an attribute name
        if (after_name) begin
            if (cls.space) begin
                mode_next = MODE_ANSKIP;
            end else if (cls.eq) begin
                mode_next = MODE_EQ;
            end else begin
                res.valueless_attr = 1'b1;
                do_top             = 1'b1;
            end
        end

        // top of the attribute loop
        if (do_top) begin
            if (cls.space) begin
                mode_next = MODE_TOPSKIP;
            end else if (cls.gt) begin
                res.close_event  = CLOSE_TAG;
                res.self_closing = ps_next;
                ps_next          = 1'b0;
                mode_next        = MODE_IDLE;
            end else if (cls.slash) begin
                ps_next   = 1'b1;
                mode_next = MODE_SLASH;
            end else if (cls.qmark) begin
                if (nq_next) begin
                    mode_next = MODE_TOP;
                end else begin
                    err_next  = ERR_QMARK;
                    mode_next = MODE_ERR;
                end
            end else if (cls.letter) begin
                res.role       = ROLE_ATTR;
                res.part_start = 1'b1;
                mode_next      = MODE_ANAME;
            end else begin
                err_next  = ERR_ATTR;
                mode_next = MODE_ERR;
            end
        end

        if (cls.newline && !was_err && line_here != LINE_MAX) begin
            line_next = line_here + LINE_W'(1);
        end else begin
            line_next = line_here;
        end

        if (last) begin
            case (mode_next)
                MODE_TEXT:    res.close_event = CLOSE_TEXT_END;
                MODE_CMT:     res.close_event = CLOSE_CMT;
                MODE_TOPSKIP: err_next = ERR_ATTR;
                MODE_SLASH:   err_next = ERR_SLASH;
                MODE_QVAL:    err_next = ERR_QUOTE;
                MODE_ANAME, MODE_ANSKIP: begin
                    res.valueless_attr = 1'b1;
                    err_next           = ERR_UNCLOSED;
                end
                MODE_LT, MODE_NAME, MODE_TOP, MODE_EQ, MODE_UVAL: begin
                    err_next = ERR_UNCLOSED;
                end
                default: begin
                end
            endcase
        end

        res.error_code  = err_next;
        res.line_number = line_here;

        // document boundary: drop all per-document state
        if (last) begin
            mode_next = MODE_FRESH;
            nq_next   = 1'b0;
            qs_next   = 1'b0;
            bdm_next  = 2'd0;
            dh_next   = 2'd0;
            bls_next  = 2'd0;
            ps_next   = 1'b0;
            err_next  = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_FRESH;
            line_reg      <= START_LINE_RESET;
            nq_reg        <= 1'b0;
            qs_reg        <= 1'b0;
            bdm_reg       <= 2'd0;
            dh_reg        <= 2'd0;
            bls_reg       <= 2'd0;
            ps_reg        <= 1'b0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (consume) begin
                mode_reg <= mode_next;
                line_reg <= line_next;
                nq_reg   <= nq_next;
                qs_reg   <= qs_next;
                bdm_reg  <= bdm_next;
                dh_reg   <= dh_next;
                bls_reg  <= bls_next;
                ps_reg   <= ps_next;
                err_reg  <= err_next;
            end
            if (pop_ready) begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            out_reg <= res;
        end
    end

`ifndef SYNTH
    a_err_only_in_err_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ERR_NONE) |-> (mode_reg == MODE_ERR))
        else $error("error latched outside error mode");

    a_last_clears_doc: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && last) |=> (mode_reg == MODE_FRESH && err_reg == ERR_NONE))
        else $error("document state not cleared after final byte");

    a_slash_pending_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        ps_reg |-> (mode_reg == MODE_SLASH || mode_reg == MODE_ERR))
        else $error("pending slash outside slash handling");

    a_err_mode_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && was_err) |=> (out_reg.role == ROLE_MARKUP && !out_reg.part_start
                                  && out_reg.close_event == CLOSE_NONE))
        else $error("result flags raised after an error");
`endif

endmodule

`default_nettype wire

/* rtl/xml_markup_tokenizer.sv */
// xml_markup_tokenizer: top level of the streaming XML markup tokenizer.
// Instantiates xmt_front, xmt_queue and xmt_engine; depends on xmt_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready/s_data) takes one document byte per
//   transaction; s_data.is_last marks the final byte of a document.
//   Result channel (m_valid/m_ready/m_data) gives exactly one result per
//   byte, in order: role, part/close flags, sticky error code, line number.
//   Configuration: pulse cfg_wr_en with cfg_wr_data to set the line number
//   a document starts on (reset value 1); write only while the block is
//   idle. The value is loaded when the next document's first byte is used.
//   Path: a byte taken on s_data passes the front register, then the
//   queue, then the engine's result register, before it is offered on m_data.
//   Throughput: one byte per cycle while m_ready is high, set by the mode
//   update in the engine.
//   Stalls: when m_ready is low the result register holds, the engine stops
//   and the queue absorbs up to QUEUE_DEPTH bytes plus one in the front
//   register before s_ready drops.
//   Reset (aresetn low, synchronous): all channels empty, parser in idle
//   mode at document start, start line back to 1.
`default_nettype none

module xml_markup_tokenizer #(
    parameter int unsigned QUEUE_DEPTH = xmt_pkg::QUEUE_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire xmt_pkg::in_t               s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output xmt_pkg::out_t                   m_data,
    input  wire logic                       cfg_wr_en,
    input  wire logic [xmt_pkg::LINE_W-1:0] cfg_wr_data
);
    import xmt_pkg::*;

    // start line register, written with no handshake
    logic [LINE_W-1:0] start_line_reg;

    // front -> queue transaction
    logic   push_valid;
    logic   push_ready;
    entry_t push_data;

    // queue -> engine transaction
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_line_reg <= START_LINE_RESET;
        end else if (cfg_wr_en) begin
            start_line_reg <= cfg_wr_data;
        end
    end

    // Classify each byte as it arrives
    xmt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple intake from the parser so each side stalls on its own
    xmt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Advance the parse mode and register one result per byte
    xmt_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_line (start_line_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
